>>> hdl/bpar_pkg.sv
// shared types and constants for the button auto-repeat block
// no dependencies; imported by bpar_lane, bpar_merge and button_press_auto_repeat
package bpar_pkg;

  localparam int LVL_W           = 6;   // width of the level sample
  localparam int TIME_W          = 32;  // millisecond timestamp width
  localparam int INTV_W          = 16;  // repeat interval width
  localparam int IDX_W           = 3;   // button index width
  localparam int MAX_BUTTONS     = 8;   // largest button count the index can name
  localparam int NUM_BUTTONS_DEF = 6;

  localparam logic [INTV_W-1:0] INTERVAL_RESET = 16'd750;

  // what one lane found for the current sample
  typedef struct packed {
    logic emit;  // lane has an event for this sample
    logic rep;   // event is an auto-repeat, else a plain press
  } bpar_evt_t;

endpackage

>>> hdl/button_press_auto_repeat.sv
// Button auto-repeat event generator. Each input beat is one poll sample
// (button levels plus a millisecond timestamp); a release with no repeat
// during the hold gives a plain press event, and a held button gives one
// repeat event each time more than the interval has passed. The sample's
// state update happens in the cycle it is accepted, in one lane per button,
// each a 32-bit subtract and compare. Events leave one per cycle while
// out_ready is high, lowest button first, with last_of_run on the final one;
// a sample with events holds the output until its last event is taken, and
// the next sample is accepted in the cycle its last event is taken. cfg_ready
// is always high; write the interval only while no events are pending.
// depends on bpar_pkg, bpar_lane, bpar_merge
module button_press_auto_repeat #(
  parameter int NUM_BUTTONS = bpar_pkg::NUM_BUTTONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpar_pkg::INTV_W-1:0]   cfg_repeat_interval_ms,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bpar_pkg::LVL_W-1:0]    in_button_levels,
  input  logic [bpar_pkg::TIME_W-1:0]   in_now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bpar_pkg::IDX_W-1:0]    out_button_index,
  output logic                          out_is_repeat,
  output logic                          out_last_of_run
);
  import bpar_pkg::*;

  logic [INTV_W-1:0]                interval_r;
  logic [NUM_BUTTONS-1:0]           prev_levels_r;
  logic [NUM_BUTTONS-1:0]           levels;
  bpar_evt_t [NUM_BUTTONS-1:0]      evt;
  logic                             load;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      interval_r <= cfg_repeat_interval_ms;
    end
  end

  // buttons past the sample width read as released
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lvl
    if (b < LVL_W) begin : g_in
      assign levels[b] = in_button_levels[b];
    end else begin : g_off
      assign levels[b] = 1'b0;
    end
  end

  assign load = in_valid && in_ready;

  // previous levels, all released after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_levels_r <= '0;
    end else if (load) begin
      prev_levels_r <= levels;
    end
  end

  // one lane per button
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    bpar_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (load),
      .cur      (levels[b]),
      .prev     (prev_levels_r[b]),
      .now_ms   (in_now_ms),
      .interval (interval_r),
      .evt      (evt[b])
    );
  end

  // event serializer
  bpar_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .evt              (evt),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_button_index (out_button_index),
    .out_is_repeat    (out_is_repeat),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

>>> hdl/bpar_lane.sv
// one button lane: edge detect, press time and repeat flag for a single button
// depends on bpar_pkg
module bpar_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic                          cur,
  input  logic                          prev,
  input  logic [bpar_pkg::TIME_W-1:0]   now_ms,
  input  logic [bpar_pkg::INTV_W-1:0]   interval,
  output bpar_pkg::bpar_evt_t           evt
);
  import bpar_pkg::*;

  logic [TIME_W-1:0] press_time_r, press_time_nxt;
  logic              repeat_sent_r, repeat_sent_nxt;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] interval_ext;
  logic              expired;

  // elapsed time wraps modulo 2^32
  assign interval_ext = {{(TIME_W-INTV_W){1'b0}}, interval};
  assign elapsed      = now_ms - press_time_r;
  assign expired      = elapsed > interval_ext;

  // per-button decision for this sample
  always_comb begin
    press_time_nxt  = press_time_r;
    repeat_sent_nxt = repeat_sent_r;
    evt             = '0;
    if (cur && !prev) begin
      press_time_nxt = now_ms;
    end else if (!cur && prev) begin
      evt.emit        = !repeat_sent_r;
      repeat_sent_nxt = 1'b0;
      press_time_nxt  = '0;
    end else if (cur && prev && expired) begin
      press_time_nxt  = press_time_r + interval_ext;
      repeat_sent_nxt = 1'b1;
      evt.emit        = 1'b1;
      evt.rep         = 1'b1;
    end
  end

  // state moves only when the sample beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_time_r  <= '0;
      repeat_sent_r <= 1'b0;
    end else if (load) begin
      press_time_r  <= press_time_nxt;
      repeat_sent_r <= repeat_sent_nxt;
    end
  end

endmodule

>>> hdl/bpar_merge.sv
// merges the lane events of one sample and sends them out lowest button first
// depends on bpar_pkg
module bpar_merge #(
  parameter int NUM_BUTTONS = bpar_pkg::NUM_BUTTONS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  bpar_pkg::bpar_evt_t [NUM_BUTTONS-1:0] evt,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bpar_pkg::IDX_W-1:0]            out_button_index,
  output logic                                  out_is_repeat,
  output logic                                  out_last_of_run
);
  import bpar_pkg::*;

  logic [NUM_BUTTONS-1:0] pend_r, pend_nxt;
  logic [NUM_BUTTONS-1:0] rep_r, rep_nxt;
  logic [NUM_BUTTONS-1:0] low_bit;
  logic [NUM_BUTTONS-1:0] new_emit, new_rep;
  logic [IDX_W-1:0]       idx;
  logic                   single;
  logic                   load;
  logic                   take;

  // lowest pending button and whether it is the last one
  assign low_bit = pend_r & (~pend_r + 1'b1);
  assign single  = (pend_r & (pend_r - 1'b1)) == '0;

  always_comb begin
    idx = '0;
    for (int b = NUM_BUTTONS - 1; b >= 0; b--) begin
      if (pend_r[b]) idx = IDX_W'(b);
    end
  end

  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      new_emit[b] = evt[b].emit;
      new_rep[b]  = evt[b].rep;
    end
  end

  // a new sample is taken once the last pending beat leaves
  assign out_valid        = |pend_r;
  assign take             = out_valid && out_ready;
  assign in_ready         = !out_valid || (out_ready && single);
  assign load             = in_valid && in_ready;
  assign out_button_index = idx;
  assign out_is_repeat    = |(rep_r & low_bit);
  assign out_last_of_run  = single;

  always_comb begin
    pend_nxt = pend_r;
    rep_nxt  = rep_r;
    if (take) pend_nxt = pend_r & ~low_bit;
    if (load) begin
      pend_nxt = new_emit;
      rep_nxt  = new_rep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rep_r <= rep_nxt;
  end

  // checks on the event queue
  a_hold_without_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (!take && !load) |=> $stable(pend_r))
    else $error("pending events changed with no beat");

  a_last_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |-> ($countones(pend_r) == 1))
    else $error("last_of_run with more than one pending event");

  a_ready_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && out_valid) |-> (out_ready && $countones(pend_r) == 1))
    else $error("new sample accepted while events remain");

  a_one_per_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !load) |=> ($countones(pend_r) == $countones($past(pend_r)) - 1))
    else $error("output beat did not retire exactly one event");

endmodule
